>>> src/rce_pkg.sv
// Shared types and constants of the rank correlation engine.
package rce_pkg;

  typedef struct packed {
    logic signed [31:0] pred;
    logic signed [31:0] tgt;
    logic               last;
    logic               keep;
    logic               ovf;
  } rce_item_t;

  typedef struct packed {
    logic        rank_mode;
    logic [31:0] var_floor;
  } rce_cfg_t;

  typedef struct packed {
    logic signed [15:0] corr;
    logic               degen;
    logic               ovf;
    logic [6:0]         count;
  } rce_result_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_FLOOR = 1'd1;

  localparam int unsigned SQ_W = 64;
  localparam logic [SQ_W-1:0] SQ_BIT_INIT = 64'h4000_0000_0000_0000;

  localparam int unsigned DIV_NUM_W = 56;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd55;
  localparam int unsigned REM_W = 33;
  localparam int unsigned FRAC_SH = 15;
  localparam logic [40:0] CM_LIMIT = 41'h100_0000_0000;
  localparam logic [DIV_NUM_W-1:0] POS_MAX = 56'd32767;
  localparam logic [DIV_NUM_W-1:0] NEG_MAX = 56'd32768;

endpackage

>>> src/rank_correlation_engine_core.sv
// A pair is accepted while the queue has room; the back end moves queued pairs into the
// pair memory one per cycle while idle. After the last pair, rank mode sweeps the pair
// memory through one read port. Then come the sums, the serial multiplier, the normalize
// and shift steps, the square root, and the divide and saturate steps.
// While one set is processed, pairs of the next set wait in the queue until it fills.
// Reset clears control and sets rank mode with floor 0; the memories are not cleared.
module rank_correlation_engine_core import rce_pkg::*; #(
  parameter int unsigned MAX_PAIRS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_prediction,
  input  logic signed [31:0]   in_target,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_correlation,
  output logic                 out_degenerate,
  output logic                 out_overflow,
  output logic [6:0]           out_pair_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  rce_cfg_t    cfg_r;
  rce_item_t   f_item, b_item;
  rce_result_t res;
  logic        q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rank_mode <= 1'b1;
      cfg_r.var_floor <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RANK_MODE: cfg_r.rank_mode <= cfg_data[0];
        CFG_VAR_FLOOR: cfg_r.var_floor <= cfg_data;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  rce_front #(.MAX_PAIRS(MAX_PAIRS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_prediction (in_prediction),
    .in_target     (in_target),
    .in_last       (in_last),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (f_item)
  );

  rce_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (b_item),
    .empty     (q_empty)
  );

  rce_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (b_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_correlation = res.corr;
  assign out_degenerate  = res.degen;
  assign out_overflow    = res.ovf;
  assign out_pair_count  = res.count;

endmodule

>>> src/rce_fifo.sv
// Two-entry request queue between the front and the back.
module rce_fifo import rce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rce_item_t push_item,
  output logic      full,
  input  logic      pop,
  output rce_item_t pop_item,
  output logic      empty
);

  rce_item_t  ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> src/rce_front.sv
// Front end: accepts pairs and marks each as kept or dropped for capacity.
module rce_front import rce_pkg::*; #(
  parameter int unsigned MAX_PAIRS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_prediction,
  input  logic signed [31:0] in_target,
  input  logic               in_last,
  input  logic               q_full,
  output logic               q_push,
  output rce_item_t          q_item
);

  localparam int unsigned NW = $clog2(MAX_PAIRS + 1);

  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          keep;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign keep     = (cnt_r < NW'(MAX_PAIRS));
  assign q_item   = '{pred: in_prediction, tgt: in_target, last: in_last,
                      keep: keep, ovf: ovf_r | !keep};

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (in_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (keep) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

>>> src/rce_smul.sv
// Shift-and-add signed multiplier, one multiplier bit per cycle.
module rce_smul #(
  parameter int unsigned A_W = 77,
  parameter int unsigned B_W = 39
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [A_W-1:0] prod
);

  localparam int unsigned CNTW = $clog2(B_W + 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [A_W-1:0]  am_r;
  logic [B_W-1:0]  bm_r;
  logic [A_W-1:0]  acc_r;
  logic            neg_r;
  logic [A_W-1:0]  prod_r;
  logic            done_r;

  assign done = done_r;
  assign prod = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        am_r   <= a[A_W-1] ? (~a + 1'b1) : a;
        bm_r   <= b[B_W-1] ? (~b + 1'b1) : b;
        neg_r  <= a[A_W-1] ^ b[B_W-1];
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r == CNTW'(B_W)) begin
          prod_r <= neg_r ? (~acc_r + 1'b1) : acc_r;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          if (bm_r[0]) acc_r <= acc_r + am_r;
          am_r  <= am_r << 1;
          bm_r  <= bm_r >> 1;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

endmodule

>>> src/rce_back.sv
// Back end: pair memories, rank sweep, sums and the correlation sequencer.
module rce_back import rce_pkg::*; #(
  parameter int unsigned MAX_PAIRS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rce_cfg_t    cfg,
  input  logic        q_empty,
  output logic        q_pop,
  input  rce_item_t   q_item,
  input  logic        out_ready,
  output logic        out_valid,
  output rce_result_t out_res
);

  localparam int unsigned IW  = $clog2(MAX_PAIRS);
  localparam int unsigned NW  = $clog2(MAX_PAIRS + 1);
  localparam int unsigned S1W = 33 + IW;
  localparam int unsigned AW  = 64 + IW;
  localparam int unsigned CW  = 65 + 2 * IW;
  localparam int unsigned RKW = NW + 2;
  localparam int unsigned SHW = $clog2(CW + 1);
  localparam int unsigned TW  = NW + 34;

  localparam logic [2:0] M_NXX = 3'd0;
  localparam logic [2:0] M_NYY = 3'd1;
  localparam logic [2:0] M_NXY = 3'd2;
  localparam logic [2:0] M_XX  = 3'd3;
  localparam logic [2:0] M_YY  = 3'd4;
  localparam logic [2:0] M_XY  = 3'd5;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_RLD   = 17'h00002,
    S_RHOLD = 17'h00004,
    S_RSCAN = 17'h00008,
    S_RWR   = 17'h00010,
    S_SUM   = 17'h00020,
    S_MUL   = 17'h00040,
    S_CHK   = 17'h00080,
    S_NORM  = 17'h00100,
    S_PAR   = 17'h00200,
    S_CSH   = 17'h00400,
    S_PROD  = 17'h00800,
    S_SQRT  = 17'h01000,
    S_DIVI  = 17'h02000,
    S_DIV   = 17'h04000,
    S_SAT   = 17'h08000,
    S_FIN   = 17'h10000
  } rce_state_t;

  rce_state_t state_r;

  logic signed [31:0] pmem [MAX_PAIRS];
  logic signed [31:0] tmem [MAX_PAIRS];
  logic [RKW-1:0]     prk  [MAX_PAIRS];
  logic [RKW-1:0]     trk  [MAX_PAIRS];

  logic signed [31:0] rd_p_r, rd_t_r;
  logic [RKW-1:0]     rd_pr_r, rd_tr_r;
  logic [IW-1:0]      rd_addr;

  logic [NW-1:0] wr_cnt_r, n_r, i_r, j_r;
  logic [NW-1:0] lx_r, ex_r, ly_r, ey_r;
  logic          ovf_r, degen_r, neg_r;
  logic signed [31:0] xi_r, yi_r;
  logic          cv_r, v1_r, v2_r;

  logic signed [31:0] xv_r, yv_r;
  logic signed [63:0] mxx_r, myy_r, mxy_r;
  logic signed [S1W-1:0] s1x_r, s1y_r;
  logic signed [AW-1:0]  s2x_r, s2y_r, sxy_r;

  logic [2:0]    msel_r;
  logic          mwait_r;
  logic [CW-1:0] ma, mprod;
  logic [S1W-1:0] mb;
  logic          mstart, mdone;

  logic [CW-1:0]  cxx_r, cyy_r, cxy_r, a_r, b_r, c_r;
  logic [TW-1:0]  thr_r, nf;
  logic [SHW-1:0] sx_r, sy_r, h_r;
  logic [SHW:0]   hs;
  logic           odd;

  logic [61:0]     ab_w;
  logic [SQ_W-1:0] sq_x_r, sq_res_r, sq_bit_r, trial;

  logic [31:0]          dd;
  logic [40:0]          cm;
  logic [DIV_NUM_W-1:0] num, dv_q_r, qs;
  logic [REM_W-1:0]     dv_rem_r, rt;
  logic [31:0]          dv_d_r;
  logic [DIV_CNT_W-1:0] dv_cnt_r;
  logic                 ge;

  logic signed [15:0] corr_r;
  logic               out_valid_r;
  rce_result_t        out_res_r;

  logic          issue, mem_we, rk_we;
  logic [NW-1:0] n_cur;
  logic [RKW-1:0] rank_x, rank_y;
  logic signed [31:0] xs, ys;
  logic          abig, bbig;
  logic          degen_now;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign q_pop  = (state_r == S_IDLE) && !q_empty;
  assign mem_we = q_pop && q_item.keep;
  assign rk_we  = (state_r == S_RWR);
  assign n_cur  = wr_cnt_r + NW'(q_item.keep);
  assign issue  = (j_r < n_r);
  assign rd_addr = (state_r == S_RLD) ? i_r[IW-1:0] : j_r[IW-1:0];

  // Doubled average rank: two per smaller value, one per equal value, plus one.
  assign rank_x = (RKW'(lx_r) << 1) + RKW'(ex_r) + 1'b1;
  assign rank_y = (RKW'(ly_r) << 1) + RKW'(ey_r) + 1'b1;

  assign xs = cfg.rank_mode ? $signed(32'(rd_pr_r)) : rd_p_r;
  assign ys = cfg.rank_mode ? $signed(32'(rd_tr_r)) : rd_t_r;

  always_comb begin
    case (msel_r)
      M_NXX:   begin ma = CW'(s2x_r); mb = S1W'({1'b0, n_r}); end
      M_NYY:   begin ma = CW'(s2y_r); mb = S1W'({1'b0, n_r}); end
      M_NXY:   begin ma = CW'(sxy_r); mb = S1W'({1'b0, n_r}); end
      M_XX:    begin ma = CW'(s1x_r); mb = s1x_r; end
      M_YY:    begin ma = CW'(s1y_r); mb = s1y_r; end
      M_XY:    begin ma = CW'(s1x_r); mb = s1y_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign mstart = (state_r == S_MUL) && !mwait_r;

  rce_smul #(.A_W(CW), .B_W(S1W)) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .prod  (mprod)
  );

  assign nf = TW'(n_r) * TW'(cfg.var_floor);
  assign degen_now = (cxx_r == '0) || (cxx_r < CW'(thr_r)) ||
                     (cyy_r == '0) || (cyy_r < CW'(thr_r));

  assign abig = |a_r[CW-1:31];
  assign bbig = |b_r[CW-1:31];
  assign odd  = sx_r[0] ^ sy_r[0];
  assign hs   = {1'b0, sx_r} + {1'b0, sy_r} + (SHW+1)'(odd);

  assign ab_w  = a_r[30:0] * b_r[30:0];
  assign trial = sq_res_r + sq_bit_r;

  assign dd  = (sq_res_r[31:0] == 32'd0) ? 32'd1 : sq_res_r[31:0];
  assign cm  = (c_r > CW'(CM_LIMIT)) ? CM_LIMIT : c_r[40:0];
  assign num = (DIV_NUM_W'(cm) << FRAC_SH) + DIV_NUM_W'(dd[31:1]);
  assign rt  = {dv_rem_r[REM_W-2:0], dv_q_r[DIV_NUM_W-1]};
  assign ge  = (rt >= {1'b0, dv_d_r});
  assign qs  = neg_r ? ((dv_q_r > NEG_MAX) ? NEG_MAX : dv_q_r)
                     : ((dv_q_r > POS_MAX) ? POS_MAX : dv_q_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pmem[wr_cnt_r[IW-1:0]] <= q_item.pred;
      tmem[wr_cnt_r[IW-1:0]] <= q_item.tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      prk[i_r[IW-1:0]] <= rank_x;
      trk[i_r[IW-1:0]] <= rank_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_p_r  <= pmem[rd_addr];
    rd_t_r  <= tmem[rd_addr];
    rd_pr_r <= prk[rd_addr];
    rd_tr_r <= trk[rd_addr];
  end

  always_ff @(posedge clk) begin
    thr_r <= cfg.rank_mode ? (nf << 2) : nf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      cv_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      mwait_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_item.last) begin
              wr_cnt_r <= '0;
              n_r      <= n_cur;
              ovf_r    <= q_item.ovf;
              i_r      <= '0;
              j_r      <= '0;
              s1x_r    <= '0;
              s1y_r    <= '0;
              s2x_r    <= '0;
              s2y_r    <= '0;
              sxy_r    <= '0;
              v1_r     <= 1'b0;
              v2_r     <= 1'b0;
              if (n_cur < NW'(2)) begin
                degen_r <= 1'b1;
                state_r <= S_FIN;
              end else if (cfg.rank_mode) begin
                state_r <= S_RLD;
              end else begin
                state_r <= S_SUM;
              end
            end else if (q_item.keep) begin
              wr_cnt_r <= wr_cnt_r + 1'b1;
            end
          end
        end
        S_RLD: state_r <= S_RHOLD;
        S_RHOLD: begin
          xi_r    <= rd_p_r;
          yi_r    <= rd_t_r;
          j_r     <= '0;
          lx_r    <= '0;
          ex_r    <= '0;
          ly_r    <= '0;
          ey_r    <= '0;
          cv_r    <= 1'b0;
          state_r <= S_RSCAN;
        end
        S_RSCAN: begin
          if (issue) j_r <= j_r + 1'b1;
          cv_r <= issue;
          if (cv_r) begin
            if (rd_p_r < xi_r) lx_r <= lx_r + 1'b1;
            else if (rd_p_r == xi_r) ex_r <= ex_r + 1'b1;
            if (rd_t_r < yi_r) ly_r <= ly_r + 1'b1;
            else if (rd_t_r == yi_r) ey_r <= ey_r + 1'b1;
          end
          if (!issue && !cv_r) state_r <= S_RWR;
        end
        S_RWR: begin
          i_r <= i_r + 1'b1;
          if (i_r + 1'b1 == n_r) begin
            j_r     <= '0;
            state_r <= S_SUM;
          end else begin
            state_r <= S_RLD;
          end
        end
        S_SUM: begin
          if (issue) j_r <= j_r + 1'b1;
          v1_r <= issue;
          v2_r <= v1_r;
          if (v1_r) begin
            xv_r  <= xs;
            yv_r  <= ys;
            mxx_r <= xs * xs;
            myy_r <= ys * ys;
            mxy_r <= xs * ys;
          end
          if (v2_r) begin
            s1x_r <= s1x_r + S1W'(xv_r);
            s1y_r <= s1y_r + S1W'(yv_r);
            s2x_r <= s2x_r + AW'(mxx_r);
            s2y_r <= s2y_r + AW'(myy_r);
            sxy_r <= sxy_r + AW'(mxy_r);
          end
          if (!issue && !v1_r && !v2_r) begin
            msel_r  <= M_NXX;
            mwait_r <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mstart) mwait_r <= 1'b1;
          if (mdone) begin
            case (msel_r)
              M_NXX:   cxx_r <= mprod;
              M_NYY:   cyy_r <= mprod;
              M_NXY:   cxy_r <= mprod;
              M_XX:    cxx_r <= cxx_r - mprod;
              M_YY:    cyy_r <= cyy_r - mprod;
              M_XY:    cxy_r <= cxy_r - mprod;
              default: cxy_r <= cxy_r;
            endcase
            mwait_r <= 1'b0;
            msel_r  <= msel_r + 3'd1;
            if (msel_r == M_XY) state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (degen_now) begin
            degen_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            degen_r <= 1'b0;
            a_r     <= cxx_r;
            b_r     <= cyy_r;
            c_r     <= cxy_r[CW-1] ? (~cxy_r + 1'b1) : cxy_r;
            neg_r   <= cxy_r[CW-1];
            sx_r    <= '0;
            sy_r    <= '0;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Bring both centred sums under 31 bits, counting the shifts.
          if (abig) begin
            a_r  <= a_r >> 1;
            sx_r <= sx_r + 1'b1;
          end
          if (bbig) begin
            b_r  <= b_r >> 1;
            sy_r <= sy_r + 1'b1;
          end
          if (!abig && !bbig) state_r <= S_PAR;
        end
        S_PAR: begin
          if (odd) begin
            if (sx_r != '0) a_r <= a_r >> 1;
            else b_r <= b_r >> 1;
          end
          h_r     <= hs[SHW:1];
          state_r <= S_CSH;
        end
        S_CSH: begin
          if (h_r != '0) begin
            c_r <= c_r >> 1;
            h_r <= h_r - 1'b1;
          end else begin
            state_r <= S_PROD;
          end
        end
        S_PROD: begin
          sq_x_r   <= SQ_W'(ab_w);
          sq_res_r <= '0;
          sq_bit_r <= SQ_BIT_INIT;
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_x_r >= trial) begin
            sq_x_r   <= sq_x_r - trial;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) state_r <= S_DIVI;
        end
        S_DIVI: begin
          dv_q_r   <= num;
          dv_rem_r <= '0;
          dv_d_r   <= dd;
          dv_cnt_r <= '0;
          state_r  <= S_DIV;
        end
        S_DIV: begin
          dv_rem_r <= ge ? (rt - {1'b0, dv_d_r}) : rt;
          dv_q_r   <= {dv_q_r[DIV_NUM_W-2:0], ge};
          dv_cnt_r <= dv_cnt_r + 1'b1;
          if (dv_cnt_r == DIV_LAST) state_r <= S_SAT;
        end
        S_SAT: begin
          corr_r  <= neg_r ? ('0 - qs[15:0]) : qs[15:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r) begin
            out_res_r <= '{corr: degen_r ? 16'sd0 : corr_r, degen: degen_r,
                           ovf: ovf_r, count: 7'(n_r)};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_keep_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.keep) |-> (wr_cnt_r < NW'(MAX_PAIRS)))
    else $error("kept pair arrived with the pair memory full");

  a_sums_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (!cxx_r[CW-1] && !cyy_r[CW-1]))
    else $error("centred sum of squares came out negative");

  a_norm_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAR) |-> (!abig && !bbig))
    else $error("normalized sums wider than 31 bits");

  a_load_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the finish step");
`endif

endmodule

>>> sim/rank_correlation_engine_core_tb.sv
// Self-checking testbench of the rank correlation engine core.
module rank_correlation_engine_core_tb;
  import rce_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ITEM_GOAL = 1150;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [31:0]   in_prediction;
  logic signed [31:0]   in_target;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [15:0]   out_correlation;
  logic                 out_degenerate;
  logic                 out_overflow;
  logic [6:0]           out_pair_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold_len;
  int unsigned pairs_sent;

  rank_correlation_engine_core #(.MAX_PAIRS(CAPACITY)) u_top (.*);

  class corr_scoreboard;
    logic signed [31:0] pred_mem[CAPACITY];
    logic signed [31:0] tgt_mem[CAPACITY];
    logic [7:0]         pred_rank[CAPACITY];
    logic [7:0]         tgt_rank[CAPACITY];
    int unsigned        fill;
    bit                 dropped;
    bit                 rank_on;
    logic [31:0]        floor_val;
    rce_result_t        corr_due[$];
    int unsigned        errors;

    function new();
      fill = 0;
      dropped = 0;
      rank_on = 1;
      floor_val = '0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_RANK_MODE) rank_on = data[0];
      else if (idx == CFG_VAR_FLOOR) floor_val = data;
    endfunction

    function automatic int unsigned bit_length(logic [127:0] v);
      int unsigned k;
      k = 0;
      for (int i = 0; i < 128; i++) if (v[i]) k = i + 1;
      return k;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] one_bit;
      res = 0;
      one_bit = 64'h4000_0000_0000_0000;
      while (one_bit > v) one_bit = one_bit >> 2;
      while (one_bit != 0) begin
        if (v >= res + one_bit) begin
          v = v - (res + one_bit);
          res = (res >> 1) + one_bit;
        end else begin
          res = res >> 1;
        end
        one_bit = one_bit >> 2;
      end
      return res;
    endfunction

    // Doubled average ranks: 2*less + equal + 1 stays an integer with ties.
    function void rank_vectors(int unsigned n);
      int unsigned pl, pe, tl, te;
      for (int i = 0; i < n; i++) begin
        pl = 0; pe = 0; tl = 0; te = 0;
        for (int j = 0; j < n; j++) begin
          if (pred_mem[j] < pred_mem[i]) pl++;
          else if (pred_mem[j] == pred_mem[i]) pe++;
          if (tgt_mem[j] < tgt_mem[i]) tl++;
          else if (tgt_mem[j] == tgt_mem[i]) te++;
        end
        pred_rank[i] = 8'(2 * pl + pe + 1);
        tgt_rank[i] = 8'(2 * tl + te + 1);
      end
    endfunction

    function automatic rce_result_t correlation_of_set(int unsigned n);
      rce_result_t r;
      logic signed [127:0] x, y, s1x, s1y, s2x, s2y, sxy, cxx, cyy, cxy, nn;
      logic [127:0] thresh, a, b, c;
      logic [63:0] d, q, cm;
      int unsigned sx, sy;
      bit neg;
      r.corr = '0;
      r.degen = 1'b1;
      r.ovf = dropped;
      r.count = 7'(n);
      if (n < 2) return r;
      s1x = 0; s1y = 0; s2x = 0; s2y = 0; sxy = 0;
      for (int i = 0; i < n; i++) begin
        x = rank_on ? $signed({120'd0, pred_rank[i]}) : 128'(pred_mem[i]);
        y = rank_on ? $signed({120'd0, tgt_rank[i]}) : 128'(tgt_mem[i]);
        s1x += x; s1y += y;
        s2x += x * x; s2y += y * y; sxy += x * y;
      end
      nn = 128'(n);
      cxx = nn * s2x - s1x * s1x;
      cyy = nn * s2y - s1y * s1y;
      cxy = nn * sxy - s1x * s1y;
      thresh = 128'(n) * 128'(floor_val) * (rank_on ? 128'd4 : 128'd1);
      if (cxx == 0 || 128'(cxx) < thresh || cyy == 0 || 128'(cyy) < thresh) return r;
      sx = bit_length(cxx); sx = sx > 31 ? sx - 31 : 0;
      sy = bit_length(cyy); sy = sy > 31 ? sy - 31 : 0;
      if ((sx + sy) % 2 == 1) begin
        if (sx > 0) sx++; else sy++;
      end
      a = 128'(cxx) >> sx;
      b = 128'(cyy) >> sy;
      neg = cxy < 0;
      if (neg) cxy = -cxy;
      c = 128'(cxy) >> ((sx + sy) / 2);
      d = floor_sqrt(64'(a * b));
      if (d == 0) d = 1;
      cm = (c > 128'h100_0000_0000) ? 64'h100_0000_0000 : 64'(c);
      q = (cm * 64'd32768 + d / 2) / d;
      if (neg) begin
        if (q > 32768) q = 32768;
        r.corr = -16'(q);
      end else begin
        if (q > 32767) q = 32767;
        r.corr = 16'(q);
      end
      r.degen = 1'b0;
      return r;
    endfunction

    function void note_pair(logic signed [31:0] p, logic signed [31:0] t, logic lst);
      if (fill < CAPACITY) begin
        pred_mem[fill] = p;
        tgt_mem[fill] = t;
        fill++;
      end else begin
        dropped = 1;
      end
      if (!lst) return;
      if (rank_on) rank_vectors(fill);
      corr_due.insert(corr_due.size(), correlation_of_set(fill));
      fill = 0;
      dropped = 0;
    endfunction

    function void check_result(rce_result_t got);
      rce_result_t want;
      if (corr_due.size() == 0) begin
        report("result with no set pending");
        return;
      end
      want = corr_due.pop_front();
      if (got.corr !== want.corr)
        report($sformatf("correlation %0d, expected %0d", got.corr, want.corr));
      if (got.degen !== want.degen)
        report($sformatf("degenerate %0b, expected %0b", got.degen, want.degen));
      if (got.ovf !== want.ovf)
        report($sformatf("overflow %0b, expected %0b", got.ovf, want.ovf));
      if (got.count !== want.count)
        report($sformatf("pair_count %0d, expected %0d", got.count, want.count));
    endfunction
  endclass

  corr_scoreboard sb = new();

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Acceptance is judged on values sampled at the edge, before any update lands.
  always @(posedge clk) begin
    rce_result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_pair(in_prediction, in_target, in_last);
      if (out_valid && out_ready) begin
        got.corr = out_correlation;
        got.degen = out_degenerate;
        got.ovf = out_overflow;
        got.count = out_pair_count;
        sb.check_result(got);
      end
    end
  end

  // Result side: random stalls, plus a long hold when one is requested.
  always @(posedge clk) begin
    if (rx_hold_len > 0) begin
      rx_hold_len <= rx_hold_len - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_pair(logic signed [31:0] p, logic signed [31:0] t, logic lst);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_prediction <= p;
    in_target <= t;
    in_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.corr_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value(int unsigned flavor, int unsigned i);
    case (flavor)
      0: return $urandom;
      1: return $signed(32'($urandom_range(3))) - 1;
      2: return 32'sd12345;
      3: return $signed(32'(i * 65536)) + $signed(32'($urandom_range(40000)));
      default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                         : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  // One set: most are short, a few run past capacity so pairs are dropped.
  task automatic send_set();
    int unsigned n, fp, ft, sel;
    logic signed [31:0] p, t;
    bit flip;
    sel = $urandom_range(99);
    if (sel < 4) n = 1;
    else if (sel < 10) n = $urandom_range(60, 70);
    else n = $urandom_range(2, 10);
    fp = $urandom_range(4);
    ft = $urandom_range(4);
    flip = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      p = pick_value(fp, i);
      t = (fp == 3 && $urandom_range(1)) ? (flip ? -p : p + 7) : pick_value(ft, i);
      send_pair(p, t, i == n - 1);
    end
  endtask

  initial begin
    int unsigned mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_prediction = '0;
    in_target = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_len = 0;
    pairs_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets in rank mode at reset: a lone pair, extremes, a constant
    // vector, and a perfectly reversed order.
    send_pair(32'sd5, 32'sd9, 1'b1);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    for (int i = 0; i < 3; i++) send_pair(32'sd7, 32'(i), i == 2);
    for (int i = 0; i < 4; i++) send_pair(32'(i), 32'(-i), i == 3);
    wait_drained();
    write_reg(CFG_RANK_MODE, 32'd0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_pair(32'sd1, 32'sd1, 1'b1);
    wait_drained();
    write_reg(CFG_VAR_FLOOR, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) send_pair(32'(i * 100), 32'(i), i == 2);
    wait_drained();

    mode = 0;
    while (pairs_sent < ITEM_GOAL) begin
      case (mode % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      write_reg(CFG_RANK_MODE, {31'($urandom_range(31)), 1'($urandom_range(1))});
      case ($urandom_range(5))
        0: write_reg(CFG_VAR_FLOOR, 32'hFFFF_FFFF);
        1: write_reg(CFG_VAR_FLOOR, $urandom);
        2: write_reg(CFG_VAR_FLOOR, $urandom_range(60));
        default: write_reg(CFG_VAR_FLOOR, 32'd0);
      endcase
      // Once, hold the result side off long enough for the input to back up.
      if (mode == 5) rx_hold_len = 6000;
      repeat ($urandom_range(4, 10)) send_set();
      wait_drained();
      mode++;
    end

    repeat (500) @(posedge clk);
    if (sb.errors == 0 && sb.corr_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (sb.corr_due.size() != 0) sb.report("sets left without a result");
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
